[src/rssg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_pkg
// Shared types, constants and helpers for the ramp/soak setpoint generator.
// ----------------------------------------------------------------------------
package rssg_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_JUMP    = 2'd1,
        OP_PROGRAM = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    // Configuration register map
    typedef enum logic [2:0] {
        CFG_JUMP_TARGET  = 3'd0,
        CFG_JUMP_RATE    = 3'd1,
        CFG_START_LEVEL  = 3'd2,
        CFG_START_HOLD   = 3'd3,
        CFG_PROGRAM_RATE = 3'd4,
        CFG_SECOND_LEVEL = 3'd5,
        CFG_WAIT_SECONDS = 3'd6,
        CFG_REPEAT_LIMIT = 3'd7
    } cfg_idx_t;

    localparam int CFG_DATA_W = 14;

    // Fine units are 1/600 C; 60 fine units per 0.1 C
    localparam logic signed [17:0] FINE_PER_TENTH = 18'sd60;
    localparam logic [9:0]         MIN_STEP_FINE  = 10'd60;
    localparam logic signed [18:0] CLAMP_LOW_FINE  = -19'sd6000;
    localparam logic signed [18:0] CLAMP_HIGH_FINE = 19'sd66000;
    localparam logic signed [18:0] FINE_MAX = 19'sd131071;
    localparam logic signed [18:0] FINE_MIN = -19'sd131072;

    // 0.1 C to fine units (fits 18 bits for any 12-bit input)
    function automatic logic signed [17:0] tenth_to_fine(input logic signed [11:0] v);
        logic signed [17:0] w;
        w = {{6{v[11]}}, v};
        return w * FINE_PER_TENTH;
    endfunction

endpackage

[src/rssg_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_item_if
// Input item channel: tick or command with measured temperature and fault.
// ----------------------------------------------------------------------------
interface rssg_item_if;
    import rssg_pkg::*;

    logic               valid;
    logic               ready;
    op_t                op;
    logic signed [11:0] measured_temp;
    logic               fault_present;

    modport source (output valid, output op, output measured_temp, output fault_present,
                    input ready);
    modport sink   (input valid, input op, input measured_temp, input fault_present,
                    output ready);
endinterface

[src/rssg_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_result_if
// Result channel: setpoint, mode, phase and refusal flag.
// ----------------------------------------------------------------------------
interface rssg_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] setpoint_fine;
    logic [1:0]         gen_mode;
    logic [2:0]         profile_phase;
    logic               start_refused;

    modport source (output valid, output setpoint_fine, output gen_mode,
                    output profile_phase, output start_refused, input ready);
    modport sink   (input valid, input setpoint_fine, input gen_mode,
                    input profile_phase, input start_refused, output ready);
endinterface

[src/rssg_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rssg_cfg_if;
    import rssg_pkg::*;

    logic                  valid;
    logic                  ready;
    cfg_idx_t              addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/ramp_soak_setpoint_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramp_soak_setpoint_generator
// Path: an accepted item loads the input register; the update step then loads
// the result register when that register is empty or its result is taken.
// Throughput: one item per cycle while results are taken; the single update
// step between the two registers sets this, and the input register takes one
// more item while a result waits. Config writes are always ready.
// Reset (async, rst_n low): stopped, idle, setpoint 25 C, config defaults.
// ----------------------------------------------------------------------------
module ramp_soak_setpoint_generator (
    input  logic                  clk,
    input  logic                  rst_n,
    rssg_item_if.sink             item,
    rssg_result_if.source         result,
    rssg_cfg_if.sink              cfg
);
    import rssg_pkg::*;

    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_JUMP    = 2'd1,
        MODE_PROGRAM = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TO_START = 3'd1,
        PH_HOLD     = 3'd2,
        PH_RAMP     = 3'd3,
        PH_WAIT     = 3'd4,
        PH_FINISHED = 3'd5
    } phase_t;

    // Configuration registers
    logic signed [11:0] jump_target_reg;
    logic [9:0]         jump_rate_reg;
    logic signed [11:0] start_level_reg;
    logic [13:0]        start_hold_reg;
    logic [9:0]         program_rate_reg;
    logic signed [11:0] second_level_reg;
    logic [13:0]        wait_seconds_reg;
    logic [13:0]        repeat_limit_reg;

    // Input stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic signed [11:0] s1_meas_reg;
    logic               s1_fault_reg;

    // Profile state
    mode_t              mode_reg,    mode_next;
    phase_t             phase_reg,   phase_next;
    logic signed [17:0] command_reg, command_next;
    logic [13:0]        dwell_reg,   dwell_next;
    logic [13:0]        steps_reg,   steps_next;
    logic signed [17:0] target_reg,  target_next;
    logic signed [17:0] delta_reg,   delta_next;
    logic               refused_next;

    // Result register
    logic               out_valid_reg;
    logic signed [17:0] out_setpoint_reg;
    logic [1:0]         out_mode_reg;
    logic [2:0]         out_phase_reg;
    logic               out_refused_reg;

    // Datapath helpers
    logic signed [17:0] jt_fine, sl_fine, sl2_fine;
    logic signed [17:0] ramp_tgt, ramp_out;
    logic [9:0]         ramp_speed, ramp_step;
    logic signed [18:0] ramp_diff;
    logic [18:0]        ramp_mag;
    logic signed [18:0] step_sum, step_clamped;
    logic signed [18:0] delta_raw;
    logic signed [17:0] delta_sat;
    logic               advance, fire, item_accept, stop_fire;

    // Handshake
    assign advance     = !out_valid_reg || result.ready;
    assign fire        = s1_valid_reg && advance;
    assign item.ready  = !s1_valid_reg || advance;
    assign item_accept = item.valid && item.ready;
    assign cfg.ready   = 1'b1;
    assign stop_fire   = fire && (s1_op_reg == OP_STOP);

    assign result.valid         = out_valid_reg;
    assign result.setpoint_fine = out_setpoint_reg;
    assign result.gen_mode      = out_mode_reg;
    assign result.profile_phase = out_phase_reg;
    assign result.start_refused = out_refused_reg;

    // Levels in fine units
    assign jt_fine  = tenth_to_fine(jump_target_reg);
    assign sl_fine  = tenth_to_fine(start_level_reg);
    assign sl2_fine = tenth_to_fine(second_level_reg);

    // Shared ramp unit: jump target, start level or stepped target
    always_comb
    begin
        if (mode_reg == MODE_JUMP) begin
            ramp_tgt   = jt_fine;
            ramp_speed = jump_rate_reg;
        end else if (phase_reg == PH_TO_START) begin
            ramp_tgt   = sl_fine;
            ramp_speed = jump_rate_reg;
        end else begin
            ramp_tgt   = target_reg;
            ramp_speed = program_rate_reg;
        end
        ramp_step = (ramp_speed < MIN_STEP_FINE) ? MIN_STEP_FINE : ramp_speed;
        ramp_diff = {ramp_tgt[17], ramp_tgt} - {command_reg[17], command_reg};
        ramp_mag  = ramp_diff[18] ? 19'(-ramp_diff) : 19'(ramp_diff);
        if (ramp_speed == 10'd0 || ramp_diff == 19'sd0 || ramp_mag <= {9'd0, ramp_step})
            ramp_out = ramp_tgt;
        else if (!ramp_diff[18])
            ramp_out = command_reg + $signed({8'd0, ramp_step});
        else
            ramp_out = command_reg - $signed({8'd0, ramp_step});
    end

    // Next stepped target, clamped to -10 C .. 110 C
    always_comb
    begin
        step_sum = {target_reg[17], target_reg} + {delta_reg[17], delta_reg};
        if (step_sum < CLAMP_LOW_FINE)
            step_clamped = CLAMP_LOW_FINE;
        else if (step_sum > CLAMP_HIGH_FINE)
            step_clamped = CLAMP_HIGH_FINE;
        else
            step_clamped = step_sum;
    end

    // Step size, saturated to 18 bits
    always_comb
    begin
        delta_raw = {sl2_fine[17], sl2_fine} - {sl_fine[17], sl_fine};
        if (delta_raw > FINE_MAX)
            delta_sat = 18'sh1FFFF;
        else if (delta_raw < FINE_MIN)
            delta_sat = 18'sh20000;
        else
            delta_sat = delta_raw[17:0];
    end

    // Profile update for the item in the input stage
    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        command_next = command_reg;
        dwell_next   = dwell_reg;
        steps_next   = steps_reg;
        target_next  = target_reg;
        delta_next   = delta_reg;
        refused_next = 1'b0;
        case (s1_op_reg)
            OP_TICK:
            begin
                if (mode_reg == MODE_JUMP) begin
                    command_next = ramp_out;
                end else if (mode_reg == MODE_PROGRAM) begin
                    case (phase_reg)
                        PH_TO_START:
                        begin
                            command_next = ramp_out;
                            if (ramp_out == sl_fine) begin
                                phase_next = PH_HOLD;
                                dwell_next = '0;
                            end
                        end
                        PH_HOLD:
                        begin
                            command_next = sl_fine;
                            if (dwell_reg >= start_hold_reg) begin
                                phase_next  = PH_RAMP;
                                dwell_next  = '0;
                                target_next = sl2_fine;
                            end else begin
                                dwell_next = dwell_reg + 14'd1;
                            end
                        end
                        PH_RAMP:
                        begin
                            command_next = ramp_out;
                            if (ramp_out == target_reg) begin
                                phase_next = PH_WAIT;
                                dwell_next = '0;
                            end
                        end
                        PH_WAIT:
                        begin
                            command_next = target_reg;
                            if (dwell_reg >= wait_seconds_reg) begin
                                dwell_next = '0;
                                if (steps_reg >= repeat_limit_reg) begin
                                    phase_next = PH_FINISHED;
                                end else begin
                                    steps_next  = steps_reg + 14'd1;
                                    target_next = step_clamped[17:0];
                                    phase_next  = PH_RAMP;
                                end
                            end else begin
                                dwell_next = dwell_reg + 14'd1;
                            end
                        end
                        PH_FINISHED:
                        begin
                            command_next = target_reg;
                        end
                        default:
                        begin
                            phase_next = PH_TO_START;
                        end
                    endcase
                end
            end
            OP_JUMP:
            begin
                if (s1_fault_reg) begin
                    refused_next = 1'b1;
                end else begin
                    mode_next    = MODE_JUMP;
                    phase_next   = PH_IDLE;
                    dwell_next   = '0;
                    steps_next   = '0;
                    command_next = tenth_to_fine(s1_meas_reg);
                end
            end
            OP_PROGRAM:
            begin
                if (s1_fault_reg) begin
                    refused_next = 1'b1;
                end else begin
                    mode_next    = MODE_PROGRAM;
                    phase_next   = PH_TO_START;
                    dwell_next   = '0;
                    steps_next   = '0;
                    delta_next   = delta_sat;
                    target_next  = sl_fine;
                    command_next = tenth_to_fine(s1_meas_reg);
                end
            end
            default:
            begin
                mode_next  = MODE_STOP;
                phase_next = PH_IDLE;
                dwell_next = '0;
                steps_next = '0;
            end
        endcase
    end

    // State, config, input stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            jump_target_reg  <= 12'sd250;
            jump_rate_reg    <= 10'd10;
            start_level_reg  <= 12'sd250;
            start_hold_reg   <= 14'd300;
            program_rate_reg <= 10'd10;
            second_level_reg <= 12'sd110;
            wait_seconds_reg <= 14'd30;
            repeat_limit_reg <= 14'd79;
            s1_valid_reg     <= 1'b0;
            s1_op_reg        <= OP_TICK;
            s1_meas_reg      <= '0;
            s1_fault_reg     <= 1'b0;
            mode_reg         <= MODE_STOP;
            phase_reg        <= PH_IDLE;
            command_reg      <= 18'sd15000;
            dwell_reg        <= '0;
            steps_reg        <= '0;
            target_reg       <= '0;
            delta_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_setpoint_reg <= '0;
            out_mode_reg     <= '0;
            out_phase_reg    <= '0;
            out_refused_reg  <= 1'b0;
        end else begin
            // register writes
            if (cfg.valid) begin
                case (cfg.addr)
                    CFG_JUMP_TARGET:  jump_target_reg  <= $signed(cfg.data[11:0]);
                    CFG_JUMP_RATE:    jump_rate_reg    <= cfg.data[9:0];
                    CFG_START_LEVEL:  start_level_reg  <= $signed(cfg.data[11:0]);
                    CFG_START_HOLD:   start_hold_reg   <= cfg.data[13:0];
                    CFG_PROGRAM_RATE: program_rate_reg <= cfg.data[9:0];
                    CFG_SECOND_LEVEL: second_level_reg <= $signed(cfg.data[11:0]);
                    CFG_WAIT_SECONDS: wait_seconds_reg <= cfg.data[13:0];
                    CFG_REPEAT_LIMIT: repeat_limit_reg <= cfg.data[13:0];
                    default:          ;
                endcase
            end

            // input stage
            if (item_accept) begin
                s1_valid_reg <= 1'b1;
                s1_op_reg    <= item.op;
                s1_meas_reg  <= item.measured_temp;
                s1_fault_reg <= item.fault_present;
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end

            // state update and result capture
            if (fire) begin
                mode_reg         <= mode_next;
                phase_reg        <= phase_next;
                command_reg      <= command_next;
                dwell_reg        <= dwell_next;
                steps_reg        <= steps_next;
                target_reg       <= target_next;
                delta_reg        <= delta_next;
                out_valid_reg    <= 1'b1;
                out_setpoint_reg <= command_next;
                out_mode_reg     <= mode_next;
                out_phase_reg    <= phase_next;
                out_refused_reg  <= refused_next;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Phase is only meaningful in program mode
    a_phase_needs_program: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_PROGRAM) |-> (phase_reg == PH_IDLE))
        else $error("phase active outside program mode");

    // Dwell timer runs only while holding or waiting
    a_dwell_in_soak: assert property (@(posedge clk) disable iff (!rst_n)
        (dwell_reg != 14'd0) |-> (phase_reg == PH_HOLD || phase_reg == PH_WAIT))
        else $error("dwell timer running outside a soak phase");

    // A stop transaction leaves the generator stopped with counters cleared
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stop_fire |=> (mode_reg == MODE_STOP && steps_reg == 14'd0 && dwell_reg == 14'd0))
        else $error("stop did not clear the profile");

    // Refused starts leave mode unchanged in the result
    a_refused_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && refused_next) |=> (mode_reg == $past(mode_reg) && out_refused_reg))
        else $error("refused start changed the mode");

    // Item stage holds while the result register is blocked
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_op_reg)))
        else $error("input stage lost an item under back-pressure");

endmodule
